/* hdl/skt_pkg.sv */
// Shared types and constants for the sorted key table.
// Used by skt_ram and sorted_key_table; depends on nothing else.
package skt_pkg;

   localparam int DEPTH_DEFAULT = 256;
   localparam int KEY_W         = 31;
   localparam int PAYLOAD_W     = 64;
   localparam int STATUS_W      = 2;
   localparam int COUNT_OUT_W   = 9;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_FOUND     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_LOOKUP = 1'b1
   } command_type;

   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

endpackage

/* hdl/sorted_key_table.sv */
// Top level of the sorted key table: sequencer, shared key comparator and output register.
// Depends on skt_pkg and skt_ram.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_command, req_card_key, req_payload
//   rsp_      out        rsp_valid/rsp_stall  rsp_status, rsp_payload_out, rsp_entry_count
//
// An insert runs a shift loop that moves one entry per cycle through the single read and
// write port of the entry memory. A lookup makes one memory read and one compare per
// probe. Reset clears only the entry count and control state; the memory is not cleared.
// A stalled response is held in the output register while the next request is taken; its
// result waits until that frees.
module sorted_key_table #(
   parameter int DEPTH = skt_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [skt_pkg::KEY_W-1:0]         req_card_key,
   input  logic [skt_pkg::PAYLOAD_W-1:0]     req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [skt_pkg::STATUS_W-1:0]      rsp_status,
   output logic [skt_pkg::PAYLOAD_W-1:0]     rsp_payload_out,
   output logic [skt_pkg::COUNT_OUT_W-1:0]   rsp_entry_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_SHIFT   = 6'b000010,
      S_PLACE   = 6'b000100,
      S_LK_READ = 6'b001000,
      S_LK_CMP  = 6'b010000,
      S_DONE    = 6'b100000
   } state_type;

   state_type                        state_ff, state_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [AW-1:0]                    idx_ff, idx_in;
   logic [CW-1:0]                    low_ff, low_in;
   logic [CW-1:0]                    hp1_ff, hp1_in;
   logic [AW-1:0]                    mid_ff, mid_in;
   logic [skt_pkg::KEY_W-1:0]        key_ff, key_in;
   logic [skt_pkg::PAYLOAD_W-1:0]    payload_ff, payload_in;
   skt_pkg::status_type              status_ff, status_in;
   logic [skt_pkg::PAYLOAD_W-1:0]    found_ff, found_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   skt_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [skt_pkg::PAYLOAD_W-1:0]    rsp_payload_out_ff, rsp_payload_out_in;
   logic [CW-1:0]                    rsp_count_ff, rsp_count_in;

   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   skt_pkg::entry_type               wr_data;
   logic [AW-1:0]                    rd_addr;
   skt_pkg::entry_type               rd_data;

   logic                             req_accept;
   logic                             key_lt;
   logic                             key_eq;
   logic [CW-1:0]                    count_dec;
   logic [AW-1:0]                    idx_dec;
   logic [AW-1:0]                    idx_dec2;
   logic [CW:0]                      mid_sum;
   skt_pkg::entry_type               new_entry;

   skt_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   // The one comparator serves both the insert scan and the binary search.
   assign key_lt = (rd_data.key < key_ff);
   assign key_eq = (rd_data.key == key_ff);

   assign count_dec = count_ff - CW'(1);
   assign idx_dec   = idx_ff - AW'(1);
   assign idx_dec2  = idx_ff - AW'(2);
   assign mid_sum   = {1'b0, low_ff} + {1'b0, hp1_ff} - (CW + 1)'(1);
   assign new_entry = '{key: key_ff, payload: payload_ff};

   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      idx_in             = idx_ff;
      low_in             = low_ff;
      hp1_in             = hp1_ff;
      mid_in             = mid_ff;
      key_in             = key_ff;
      payload_in         = payload_ff;
      status_in          = status_ff;
      found_in           = found_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_status_in      = rsp_status_ff;
      rsp_payload_out_in = rsp_payload_out_ff;
      rsp_count_in       = rsp_count_ff;
      wr_en              = 1'b0;
      wr_addr            = idx_ff;
      wr_data            = new_entry;
      rd_addr            = idx_dec2;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               key_in     = req_card_key;
               payload_in = req_payload;
               found_in   = '0;
               if (req_command == skt_pkg::CMD_INSERT) begin
                  if (count_ff == CW'(DEPTH)) begin
                     status_in = skt_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end else if (count_ff == '0) begin
                     wr_en     = 1'b1;
                     wr_addr   = '0;
                     wr_data   = '{key: req_card_key, payload: req_payload};
                     count_in  = count_ff + CW'(1);
                     status_in = skt_pkg::ST_INSERTED;
                     state_in  = S_DONE;
                  end else begin
                     rd_addr  = count_dec[AW-1:0];
                     idx_in   = count_ff[AW-1:0];
                     state_in = S_SHIFT;
                  end
               end else begin
                  low_in   = '0;
                  hp1_in   = count_ff;
                  state_in = S_LK_READ;
               end
            end
         end
         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if (key_lt) begin
               wr_data   = new_entry;
               count_in  = count_ff + CW'(1);
               status_in = skt_pkg::ST_INSERTED;
               state_in  = S_DONE;
            end else begin
               wr_data = rd_data;
               idx_in  = idx_dec;
               if (idx_ff == AW'(1)) begin
                  state_in = S_PLACE;
               end
            end
         end
         S_PLACE: begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = new_entry;
            count_in  = count_ff + CW'(1);
            status_in = skt_pkg::ST_INSERTED;
            state_in  = S_DONE;
         end
         S_LK_READ: begin
            if (low_ff < hp1_ff) begin
               mid_in   = mid_sum[AW:1];
               rd_addr  = mid_sum[AW:1];
               state_in = S_LK_CMP;
            end else begin
               status_in = skt_pkg::ST_NOT_FOUND;
               state_in  = S_DONE;
            end
         end
         S_LK_CMP: begin
            if (key_eq) begin
               found_in  = rd_data.payload;
               status_in = skt_pkg::ST_FOUND;
               state_in  = S_DONE;
            end else begin
               if (key_lt) begin
                  low_in = CW'(mid_ff) + CW'(1);
               end else begin
                  hp1_in = CW'(mid_ff);
               end
               state_in = S_LK_READ;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = status_ff;
               rsp_payload_out_in = found_ff;
               rsp_count_in       = count_ff;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff             <= idx_in;
      low_ff             <= low_in;
      hp1_ff             <= hp1_in;
      mid_ff             <= mid_in;
      key_ff             <= key_in;
      payload_ff         <= payload_in;
      status_ff          <= status_in;
      found_ff           <= found_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_payload_out_ff <= rsp_payload_out_in;
      rsp_count_ff       <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_payload_out = rsp_payload_out_ff;
   assign rsp_entry_count = skt_pkg::COUNT_OUT_W'(rsp_count_ff);

endmodule

/* hdl/skt_ram.sv */
// Entry memory of the sorted key table: one write port, one registered read port.
// Depends on skt_pkg for the entry type.
module skt_ram #(
   parameter int DEPTH = skt_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  skt_pkg::entry_type wr_data,
   input  logic [AW-1:0]      rd_addr,
   output skt_pkg::entry_type rd_data
);

   skt_pkg::entry_type store_ff [DEPTH];
   skt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
